/* hw/rtl/weno5_upwind_derivative_defines.svh */
// Assertion macros used by the checker file of the WENO5 derivative block.
`ifndef WENO5_UPWIND_DERIVATIVE_DEFINES_SVH
`define WENO5_UPWIND_DERIVATIVE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WENO_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WENO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/weno_pkg.sv */
// Package with widths, constants and helpers of the WENO5 derivative block.
package weno_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int FRAC_BITS = 16;
    localparam int RECIP_W   = 32;
    localparam int LANES     = 3;
    localparam int DIFFS     = 5;
    localparam int SAMPLES   = 6;

    // Register indexes of the configuration port.
    localparam logic REG_RECIP_X = 1'b0;
    localparam logic REG_RECIP_Y = 1'b1;
    localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(1) << FRAC_BITS;

    typedef logic [FRAC_BITS:0] ratio_t;

    // Linear weights 0.1, 0.6 and 0.3, rounded to FRAC_BITS fraction bits.
    localparam ratio_t LIN_W0 = 17'd6554;
    localparam ratio_t LIN_W1 = 17'd39322;
    localparam ratio_t LIN_W2 = 17'd19661;

    // Splitting constants for the exact divisions by 3.
    localparam logic [16:0] PH_FOLD = 17'd87381;      // (2^18 - 1) / 3
    localparam logic [26:0] S_FOLD  = 27'd89478485;   // (2^28 - 1) / 3
    localparam logic [32:0] EPS_RECIP = 33'd4503599628; // ceil(2^52 / 1e6)
    localparam int EPS_SHIFT = 52;

    // Exact floor(n / 3) for any 29-bit n.
    function automatic logic [27:0] div3(input logic [28:0] n);
        logic [58:0] p;
        p = {30'd0, n} * 59'd715827883;
        return p[58:31];
    endfunction

endpackage

/* hw/rtl/weno_div.sv */
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module weno_div #(
    parameter int NUM_W  = 54,
    parameter int SIDE_W = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [NUM_W-1:0]       num [weno_pkg::LANES],
    input  logic [NUM_W-1:0]       den [weno_pkg::LANES],
    input  logic [SIDE_W-1:0]      side_in,
    output logic                   out_valid,
    output weno_pkg::ratio_t       quot [weno_pkg::LANES],
    output logic [SIDE_W-1:0]      side_out
);
    import weno_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;

    logic [NUM_W-1:0]  rem_reg  [STAGES][LANES];
    logic [NUM_W-1:0]  den_reg  [STAGES][LANES];
    ratio_t            q_reg    [STAGES][LANES];
    logic [SIDE_W-1:0] side_reg [STAGES];
    logic [STAGES-1:0] vld_reg;

    logic [NUM_W:0]    sh_c     [STAGES][LANES];
    logic [NUM_W-1:0]  dd_c     [STAGES][LANES];
    ratio_t            qp_c     [STAGES][LANES];
    logic [NUM_W:0]    sub_c    [STAGES][LANES];
    logic              bit_c    [STAGES][LANES];
    logic [NUM_W-1:0]  rem_next [STAGES][LANES];
    ratio_t            q_next   [STAGES][LANES];

    // The first stage decides the integer bit; each later one shifts in a fraction bit.
    always_comb begin
        for (int s = 0; s < STAGES; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    sh_c[s][l] = {1'b0, num[l]};
                    dd_c[s][l] = den[l];
                    qp_c[s][l] = '0;
                end else begin
                    sh_c[s][l] = {rem_reg[s-1][l], 1'b0};
                    dd_c[s][l] = den_reg[s-1][l];
                    qp_c[s][l] = q_reg[s-1][l];
                end
                sub_c[s][l] = sh_c[s][l] - {1'b0, dd_c[s][l]};
                bit_c[s][l] = (sh_c[s][l] >= {1'b0, dd_c[s][l]});
                rem_next[s][l] = bit_c[s][l] ? sub_c[s][l][NUM_W-1:0]
                                             : sh_c[s][l][NUM_W-1:0];
                q_next[s][l] = {qp_c[s][l][FRAC_BITS-1:0], bit_c[s][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < STAGES; s++) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[s][l] <= rem_next[s][l];
                    den_reg[s][l] <= dd_c[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quot[l] = q_reg[STAGES-1][l];
        end
    end

endmodule

/* hw/rtl/weno5_upwind_derivative.sv */
// Top level of the WENO5 upwind derivative pipeline.
// This block takes six level-set samples along one axis, a side flag and an
// axis flag, and returns the fifth-order WENO (Jiang-Shu) upwind derivative
// in signed Q16.16, saturated, together with a flag that reports a
// nonpositive weight denominator (in which case the linear weights 0.1, 0.6
// and 0.3 are used). It is a fully pipelined datapath: one item can be
// accepted in every clock cycle. Its depth is set by the two 17-stage
// restoring dividers (the smoothness ratios and the weight normalization),
// plus 14 stages of scaling, candidate, smoothness and weighting arithmetic.
// The whole pipeline advances together whenever the output register is empty
// or its item is being taken, so s_ready is low only while a result is held
// at the output. The reciprocal grid steps are written through cfg_wr_en,
// cfg_index and cfg_wdata and should only change while no item is in flight.
module weno5_upwind_derivative (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic                                 cfg_index,
    input  logic [weno_pkg::RECIP_W-1:0]         cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_side,
    input  logic                                 s_axis,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_0,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_1,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_2,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_3,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_4,
    input  logic signed [weno_pkg::SAMPLE_W-1:0] s_sample_5,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [weno_pkg::SAMPLE_W-1:0] m_derivative,
    output logic                                 m_divide_fault
);
    import weno_pkg::*;

    // Widths of the intermediate values, set by their worst-case ranges.
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int PROD_W   = DIFF_W + RECIP_W;
    localparam int SCALED_W = PROD_W - FRAC_BITS;
    localparam int COMB_W   = SAMPLE_W + 5;
    localparam int PHN_W    = COMB_W - 1;
    localparam int PH_W     = 35;
    localparam int PHM_W    = PH_W - 1;
    localparam int B_W      = 34;
    localparam int C_W      = 35;
    localparam int SQ_W     = 53;
    localparam int X_W      = 55;
    localparam int EP_W     = 12;
    localparam int EPS_W    = EP_W + 1;
    localparam int D_W      = 54;
    localparam int D_SW     = D_W + 1;
    localparam int A_W      = FRAC_BITS + 1;
    localparam int SUM_W    = A_W + 1;
    localparam int PW_W     = PHM_W + A_W;
    localparam int PT_W     = PW_W - FRAC_BITS;
    localparam int ACC_W    = PT_W + 3;
    localparam int SIDE1_W  = 1 + LANES * PH_W;
    localparam int SIDE2_W  = 2 + LANES * PH_W;

    localparam logic [SCALED_W-1:0] POS_LIM =
        {{(SCALED_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SCALED_W-1:0] NEG_LIM = POS_LIM + 1'b1;
    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

    // Configuration registers.
    logic [RECIP_W-1:0] recip_x_reg;
    logic [RECIP_W-1:0] recip_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recip_x_reg <= RECIP_RESET;
            recip_y_reg <= RECIP_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RECIP_X: recip_x_reg <= cfg_wdata;
                REG_RECIP_Y: recip_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline moves as one; it holds only while the output item is stalled.
    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage valid bits for the arithmetic stages outside the dividers.
    logic [8:0] vld_reg;      // stages 0 to 8
    logic [2:0] mid_vld_reg;  // stages 9 to 11
    logic       p12_vld_reg;
    logic       d1_vld;
    logic       d2_vld;

    // Stage 0: first differences in upwind order, as sign and magnitude.
    logic signed [SAMPLE_W-1:0] samp_c [SAMPLES];
    logic signed [DIFF_W-1:0]   diff_c [DIFFS];
    logic [DIFF_W-1:0]          p0_mag_reg [DIFFS];
    logic                       p0_neg_reg [DIFFS];
    logic [RECIP_W-1:0]         p0_rc_reg;

    always_comb begin
        samp_c[0] = s_sample_0;
        samp_c[1] = s_sample_1;
        samp_c[2] = s_sample_2;
        samp_c[3] = s_sample_3;
        samp_c[4] = s_sample_4;
        samp_c[5] = s_sample_5;
        for (int k = 0; k < DIFFS; k++) begin
            if (s_side) begin
                diff_c[k] = DIFF_W'(samp_c[5-k]) - DIFF_W'(samp_c[4-k]);
            end else begin
                diff_c[k] = DIFF_W'(samp_c[k+1]) - DIFF_W'(samp_c[k]);
            end
        end
    end

    // Stage 1: scaling by the reciprocal grid step.
    logic [PROD_W-1:0]   scl_c [DIFFS];
    logic [SCALED_W-1:0] p1_mag_reg [DIFFS];
    logic                p1_neg_reg [DIFFS];

    always_comb begin
        for (int k = 0; k < DIFFS; k++) begin
            scl_c[k] = PROD_W'(p0_mag_reg[k]) * PROD_W'(p0_rc_reg);
        end
    end

    // Stage 2: sign restored and saturated differences.
    logic [SCALED_W-1:0]        neg_mag_c [DIFFS];
    logic signed [SAMPLE_W-1:0] v_c [DIFFS];
    logic signed [SAMPLE_W-1:0] p2_v_reg [DIFFS];

    always_comb begin
        for (int k = 0; k < DIFFS; k++) begin
            neg_mag_c[k] = ~p1_mag_reg[k] + 1'b1;
            if (p1_neg_reg[k]) begin
                v_c[k] = (p1_mag_reg[k] > NEG_LIM) ? SAMPLE_W'(NEG_LIM)
                                                   : neg_mag_c[k][SAMPLE_W-1:0];
            end else begin
                v_c[k] = (p1_mag_reg[k] > POS_LIM) ? SAMPLE_W'(POS_LIM)
                                                   : p1_mag_reg[k][SAMPLE_W-1:0];
            end
        end
    end

    // Stage 3: candidate numerators, smoothness terms and the largest difference.
    logic signed [COMB_W-1:0]   ve_c [DIFFS];
    logic signed [COMB_W-1:0]   phn_c [LANES];
    logic signed [COMB_W-1:0]   b_c [LANES];
    logic signed [COMB_W-1:0]   c_c [LANES];
    logic signed [SAMPLE_W-1:0] vmax_c;
    logic [PHN_W-1:0]           p3_phm_reg [LANES];
    logic                       p3_phneg_reg [LANES];
    logic [B_W-1:0]             p3_bm_reg [LANES];
    logic [C_W-1:0]             p3_cm_reg [LANES];
    logic signed [SAMPLE_W-1:0] p3_vmax_reg;

    always_comb begin
        for (int k = 0; k < DIFFS; k++) begin
            ve_c[k] = COMB_W'(p2_v_reg[k]);
        end
        phn_c[0] = ve_c[0] * 2 - ve_c[1] * 7 + ve_c[2] * 11;
        phn_c[1] = ve_c[2] * 5 - ve_c[1] + ve_c[3] * 2;
        phn_c[2] = ve_c[2] * 2 + ve_c[3] * 5 - ve_c[4];
        b_c[0] = ve_c[0] - ve_c[1] * 2 + ve_c[2];
        c_c[0] = ve_c[0] - ve_c[1] * 4 + ve_c[2] * 3;
        b_c[1] = ve_c[1] - ve_c[2] * 2 + ve_c[3];
        c_c[1] = ve_c[1] - ve_c[3];
        b_c[2] = ve_c[2] - ve_c[3] * 2 + ve_c[4];
        c_c[2] = ve_c[2] * 3 - ve_c[3] * 4 + ve_c[4];
        vmax_c = p2_v_reg[0];
        for (int k = 1; k < DIFFS; k++) begin
            if (p2_v_reg[k] > vmax_c) begin
                vmax_c = p2_v_reg[k];
            end
        end
    end

    // Stage 4: squares, epsilon product and the first division by 3 of each candidate.
    logic [2*B_W-1:0]    bsq_c [LANES];
    logic [2*C_W-1:0]    csq_c [LANES];
    logic [SAMPLE_W-1:0] vm_c;
    logic [SAMPLE_W+32:0] epp_c;
    logic [27:0]         pha_c [LANES];
    logic [SQ_W-1:0]     p4_sb_reg [LANES];
    logic [SQ_W-1:0]     p4_sc_reg [LANES];
    logic [EP_W-1:0]     p4_epm_reg;
    logic                p4_epneg_reg;
    logic [16:0]         p4_pha_reg [LANES];
    logic [16:0]         p4_phyh_reg [LANES];
    logic [17:0]         p4_phyl_reg [LANES];
    logic                p4_phneg_reg [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            bsq_c[k] = {{B_W{1'b0}}, p3_bm_reg[k]} * {{B_W{1'b0}}, p3_bm_reg[k]};
            csq_c[k] = {{C_W{1'b0}}, p3_cm_reg[k]} * {{C_W{1'b0}}, p3_cm_reg[k]};
            pha_c[k] = div3({12'd0, p3_phm_reg[k][PHN_W-1:19]});
        end
        vm_c  = p3_vmax_reg[SAMPLE_W-1] ? SAMPLE_W'(-p3_vmax_reg) : SAMPLE_W'(p3_vmax_reg);
        epp_c = {33'd0, vm_c} * {32'd0, EPS_RECIP};
    end

    // Stage 5: weighted sum of squares, epsilon, and the folded remainder of each candidate.
    logic [X_W-1:0]          x_c [LANES];
    logic [27:0]             sa_c [LANES];
    logic [16:0]             ph_rt_c [LANES];
    logic [18:0]             ph_rs_c [LANES];
    logic [27:0]             pht_c [LANES];
    logic signed [EPS_W-1:0] epv_c;
    logic [16:0]             p5_pha_reg [LANES];
    logic [1:0]              p5_phra_reg [LANES];
    logic [16:0]             p5_pht_reg [LANES];
    logic                    p5_phneg_reg [LANES];
    logic [24:0]             p5_sa_reg [LANES];
    logic [24:0]             p5_syh_reg [LANES];
    logic [27:0]             p5_syl_reg [LANES];
    logic signed [EPS_W-1:0] p5_eps_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            x_c[k]  = {2'b00, p4_sb_reg[k]} * 55'd13 + {2'b00, p4_sc_reg[k]} * 55'd3;
            sa_c[k] = div3({4'd0, x_c[k][X_W-1:30]});
            ph_rt_c[k] = p4_phyh_reg[k] - p4_pha_reg[k] * 17'd3;
            ph_rs_c[k] = {1'b0, p4_phyl_reg[k]} + {17'd0, ph_rt_c[k][1:0]};
            pht_c[k]   = div3({10'd0, ph_rs_c[k]});
        end
        epv_c = p4_epneg_reg ? -$signed({1'b0, p4_epm_reg}) : $signed({1'b0, p4_epm_reg});
        epv_c = epv_c + 13'sd1;
    end

    // Stage 6: signed candidates and the folded remainder of each smoothness sum.
    logic [PHM_W-1:0]        phm_c [LANES];
    logic [24:0]             s_rt_c [LANES];
    logic [27:0]             st_c [LANES];
    logic signed [PH_W-1:0]  p6_ph_reg [LANES];
    logic [24:0]             p6_sa_reg [LANES];
    logic [1:0]              p6_sra_reg [LANES];
    logic [26:0]             p6_st_reg [LANES];
    logic signed [EPS_W-1:0] p6_eps_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            phm_c[k] = (PHM_W'(p5_pha_reg[k]) << 18)
                     + PHM_W'(p5_phra_reg[k]) * PHM_W'(PH_FOLD)
                     + PHM_W'(p5_pht_reg[k]);
            s_rt_c[k] = p5_syh_reg[k] - p5_sa_reg[k] * 25'd3;
            st_c[k]   = div3({1'b0, p5_syl_reg[k]} + {27'd0, s_rt_c[k][1:0]});
        end
    end

    // Stage 7: weight denominators.
    logic [SQ_W-1:0]         s_c [LANES];
    logic signed [D_SW-1:0]  p7_d_reg [LANES];
    logic signed [PH_W-1:0]  p7_ph_reg [LANES];

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            s_c[k] = (SQ_W'(p6_sa_reg[k]) << 28)
                   + SQ_W'(p6_sra_reg[k]) * SQ_W'(S_FOLD)
                   + SQ_W'(p6_st_reg[k]);
        end
    end

    // Stage 8: fault detection and the smallest denominator.
    logic           fault_c;
    logic [D_W-1:0] dmin_c;
    logic [D_W-1:0] p8_d_reg [LANES];
    logic [D_W-1:0] p8_dmin_reg;
    logic           p8_fault_reg;
    logic signed [PH_W-1:0] p8_ph_reg [LANES];

    always_comb begin
        fault_c = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            if (p7_d_reg[k][D_SW-1] || (p7_d_reg[k] == '0)) begin
                fault_c = 1'b1;
            end
        end
        dmin_c = p7_d_reg[0][D_W-1:0];
        for (int k = 1; k < LANES; k++) begin
            if (p7_d_reg[k][D_W-1:0] < dmin_c) begin
                dmin_c = p7_d_reg[k][D_W-1:0];
            end
        end
    end

    // First divider: Dmin / D_k for each stencil.
    logic [D_W-1:0]     d1_num [LANES];
    logic [SIDE1_W-1:0] d1_side_in;
    logic [SIDE1_W-1:0] d1_side_out;
    ratio_t             d1_q [LANES];

    always_comb begin
        d1_side_in[SIDE1_W-1] = p8_fault_reg;
        for (int k = 0; k < LANES; k++) begin
            d1_num[k] = p8_dmin_reg;
            d1_side_in[k*PH_W +: PH_W] = p8_ph_reg[k];
        end
    end

    weno_div #(
        .NUM_W  (D_W),
        .SIDE_W (SIDE1_W)
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vld_reg[8]),
        .num       (d1_num),
        .den       (p8_d_reg),
        .side_in   (d1_side_in),
        .out_valid (d1_vld),
        .quot      (d1_q),
        .side_out  (d1_side_out)
    );

    // Stages 9 to 11: squared ratios, unnormalized weights and their sum.
    logic [2*A_W-1:0]   rr_c [LANES];
    logic [2*A_W-1:0]   aw_c [LANES];
    ratio_t             lin_c [LANES];
    logic [A_W-1:0]     p9_rr_reg [LANES];
    logic [SIDE1_W-1:0] p9_side_reg;
    logic [A_W-1:0]     p10_a_reg [LANES];
    logic [SIDE1_W-1:0] p10_side_reg;
    logic [A_W-1:0]     p11_a_reg [LANES];
    logic [SUM_W-1:0]   p11_sum_reg;
    logic [SIDE1_W-1:0] p11_side_reg;

    always_comb begin
        lin_c[0] = LIN_W0;
        lin_c[1] = LIN_W1;
        lin_c[2] = LIN_W2;
        for (int k = 0; k < LANES; k++) begin
            rr_c[k] = {{A_W{1'b0}}, d1_q[k]} * {{A_W{1'b0}}, d1_q[k]};
            aw_c[k] = {{A_W{1'b0}}, p9_rr_reg[k]} * {{A_W{1'b0}}, lin_c[k]};
        end
    end

    // Second divider: normalizes each weight by the sum of all three.
    logic [SUM_W-1:0]   d2_num [LANES];
    logic [SUM_W-1:0]   d2_den [LANES];
    logic [SIDE2_W-1:0] d2_side_in;
    logic [SIDE2_W-1:0] d2_side_out;
    ratio_t             d2_q [LANES];

    always_comb begin
        d2_side_in[SIDE2_W-2:0] = p11_side_reg;
        d2_side_in[SIDE2_W-1]   = p11_side_reg[SIDE1_W-1] || (p11_sum_reg == '0);
        for (int k = 0; k < LANES; k++) begin
            d2_num[k] = {1'b0, p11_a_reg[k]};
            d2_den[k] = p11_sum_reg;
        end
    end

    weno_div #(
        .NUM_W  (SUM_W),
        .SIDE_W (SIDE2_W)
    ) u_weight_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (mid_vld_reg[2]),
        .num       (d2_num),
        .den       (d2_den),
        .side_in   (d2_side_in),
        .out_valid (d2_vld),
        .quot      (d2_q),
        .side_out  (d2_side_out)
    );

    // Stage 12: candidate times weight, as sign and magnitude.
    logic signed [PH_W-1:0] fph_c [LANES];
    logic [PHM_W-1:0]       fphm_c [LANES];
    ratio_t                 w_c [LANES];
    logic [PW_W-1:0]        pw_c [LANES];
    logic [PT_W-1:0]        p12_pm_reg [LANES];
    logic                   p12_neg_reg [LANES];
    logic                   p12_fault_reg;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            fph_c[k]  = $signed(d2_side_out[k*PH_W +: PH_W]);
            fphm_c[k] = fph_c[k][PH_W-1] ? PHM_W'(-fph_c[k]) : PHM_W'(fph_c[k]);
            w_c[k]    = d2_side_out[SIDE2_W-1] ? lin_c[k] : d2_q[k];
            pw_c[k]   = PW_W'(fphm_c[k]) * PW_W'(w_c[k]);
        end
    end

    // Stage 13: final sum and saturation into the output register.
    logic signed [ACC_W-1:0] term_c [LANES];
    logic signed [ACC_W-1:0] acc_c;
    logic signed [SAMPLE_W-1:0] out_c;
    logic signed [SAMPLE_W-1:0] m_derivative_reg;
    logic                       m_fault_reg;

    always_comb begin
        acc_c = '0;
        for (int k = 0; k < LANES; k++) begin
            term_c[k] = $signed({3'b000, p12_pm_reg[k]});
            if (p12_neg_reg[k]) begin
                term_c[k] = -term_c[k];
            end
            acc_c = acc_c + term_c[k];
        end
        if (acc_c > ACC_MAX) begin
            out_c = ACC_MAX[SAMPLE_W-1:0];
        end else if (acc_c < ACC_MIN) begin
            out_c = ACC_MIN[SAMPLE_W-1:0];
        end else begin
            out_c = acc_c[SAMPLE_W-1:0];
        end
    end

    // Valid bits travel with the data and are the only cleared pipeline state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            mid_vld_reg <= '0;
            p12_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[7:0], s_valid};
            mid_vld_reg <= {mid_vld_reg[1:0], d1_vld};
            p12_vld_reg <= d2_vld;
            m_valid_reg <= p12_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < DIFFS; k++) begin
                p0_mag_reg[k] <= diff_c[k][DIFF_W-1] ? DIFF_W'(-diff_c[k]) : DIFF_W'(diff_c[k]);
                p0_neg_reg[k] <= diff_c[k][DIFF_W-1];
                p1_mag_reg[k] <= scl_c[k][PROD_W-1:FRAC_BITS];
                p1_neg_reg[k] <= p0_neg_reg[k];
                p2_v_reg[k]   <= v_c[k];
            end
            p0_rc_reg   <= s_axis ? recip_y_reg : recip_x_reg;
            p3_vmax_reg <= vmax_c;
            p4_epm_reg   <= epp_c[EPS_SHIFT+EP_W-1:EPS_SHIFT];
            p4_epneg_reg <= p3_vmax_reg[SAMPLE_W-1];
            p5_eps_reg   <= epv_c;
            p6_eps_reg   <= p5_eps_reg;
            for (int k = 0; k < LANES; k++) begin
                p3_phm_reg[k]   <= phn_c[k][COMB_W-1] ? PHN_W'(-phn_c[k]) : PHN_W'(phn_c[k]);
                p3_phneg_reg[k] <= phn_c[k][COMB_W-1];
                p3_bm_reg[k]    <= b_c[k][COMB_W-1] ? B_W'(-b_c[k]) : B_W'(b_c[k]);
                p3_cm_reg[k]    <= c_c[k][COMB_W-1] ? C_W'(-c_c[k]) : C_W'(c_c[k]);

                p4_sb_reg[k]    <= SQ_W'(bsq_c[k][2*B_W-1:FRAC_BITS]);
                p4_sc_reg[k]    <= SQ_W'(csq_c[k][2*C_W-1:FRAC_BITS]);
                p4_pha_reg[k]   <= pha_c[k][16:0];
                p4_phyh_reg[k]  <= p3_phm_reg[k][PHN_W-1:19];
                p4_phyl_reg[k]  <= p3_phm_reg[k][18:1];
                p4_phneg_reg[k] <= p3_phneg_reg[k];

                p5_pha_reg[k]   <= p4_pha_reg[k];
                p5_phra_reg[k]  <= ph_rt_c[k][1:0];
                p5_pht_reg[k]   <= pht_c[k][16:0];
                p5_phneg_reg[k] <= p4_phneg_reg[k];
                p5_sa_reg[k]    <= sa_c[k][24:0];
                p5_syh_reg[k]   <= x_c[k][X_W-1:30];
                p5_syl_reg[k]   <= x_c[k][29:2];

                p6_ph_reg[k]  <= p5_phneg_reg[k] ? -$signed({1'b0, phm_c[k]})
                                                 : $signed({1'b0, phm_c[k]});
                p6_sa_reg[k]  <= p5_sa_reg[k];
                p6_sra_reg[k] <= s_rt_c[k][1:0];
                p6_st_reg[k]  <= st_c[k][26:0];

                p7_d_reg[k]  <= $signed({2'b00, s_c[k]}) + D_SW'(p6_eps_reg);
                p7_ph_reg[k] <= p6_ph_reg[k];

                p8_d_reg[k]  <= p7_d_reg[k][D_W-1:0];
                p8_ph_reg[k] <= p7_ph_reg[k];

                p9_rr_reg[k] <= rr_c[k][FRAC_BITS+A_W-1:FRAC_BITS];
                p10_a_reg[k] <= aw_c[k][FRAC_BITS+A_W-1:FRAC_BITS];
                p11_a_reg[k] <= p10_a_reg[k];

                p12_pm_reg[k]  <= pw_c[k][PW_W-1:FRAC_BITS];
                p12_neg_reg[k] <= fph_c[k][PH_W-1];
            end
            p8_dmin_reg  <= dmin_c;
            p8_fault_reg <= fault_c;
            p9_side_reg  <= d1_side_out;
            p10_side_reg <= p9_side_reg;
            p11_side_reg <= p10_side_reg;
            p11_sum_reg  <= SUM_W'(p10_a_reg[0]) + SUM_W'(p10_a_reg[1]) + SUM_W'(p10_a_reg[2]);
            p12_fault_reg    <= d2_side_out[SIDE2_W-2];
            m_derivative_reg <= out_c;
            m_fault_reg      <= p12_fault_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_derivative   = m_derivative_reg;
    assign m_divide_fault = m_fault_reg;

endmodule

/* hw/rtl/weno5_upwind_derivative_chk.sv */
// Port-level checker for the WENO5 derivative block, bound to the top level.
`include "weno5_upwind_derivative_defines.svh"

module weno5_upwind_derivative_chk (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [weno_pkg::SAMPLE_W-1:0] m_derivative,
    input logic                                 m_divide_fault
);
    import weno_pkg::*;

    // A stalled result item must hold its value.
    `WENO_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_derivative) && $stable(m_divide_fault),
        "result item changed while stalled")

    // With the output register empty the pipeline must take items.
    `WENO_ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready,
        "input not ready with empty output")

    // A stalled output freezes the pipeline, so nothing may enter.
    `WENO_ASSERT_IMPLIES(a_freeze_on_stall, aclk, aresetn, m_valid && !m_ready, !s_ready,
        "input accepted while output stalled")

    // A result being taken always lets the pipeline move.
    `WENO_ASSERT_IMPLIES(a_ready_on_take, aclk, aresetn, m_ready, s_ready,
        "input not ready while output drains")

endmodule

bind weno5_upwind_derivative weno5_upwind_derivative_chk u_chk (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the WENO5 upwind derivative pipeline.
`timescale 1ns / 1ps

module tb_top;
    import weno_pkg::*;

    localparam int  IDLE_WAIT  = 60;     // a little beyond the pipeline latency
    localparam int  STALL_LIMIT = 5000;  // cycles without any accepted item
    localparam int  LONG_HOLD  = 300;    // receiver hold-off for the pressure test
    localparam logic [63:0] SQ_CAP  = (64'd1 << 58) - 64'd1;
    localparam logic [63:0] BIG_CAP = (64'd1 << 62) - 64'd1;

    typedef struct packed {
        logic                           side;
        logic                           axis;
        logic [SAMPLES-1:0][SAMPLE_W-1:0] smp;
    } stencil_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] deriv;
        logic                       fault;
    } deriv_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic cfg_index = REG_RECIP_X;
    logic [RECIP_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_side = 1'b0;
    logic s_axis = 1'b0;
    logic signed [SAMPLE_W-1:0] s_sample_0 = '0, s_sample_1 = '0, s_sample_2 = '0;
    logic signed [SAMPLE_W-1:0] s_sample_3 = '0, s_sample_4 = '0, s_sample_5 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_derivative;
    logic m_divide_fault;

    weno5_upwind_derivative dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_side(s_side), .s_axis(s_axis),
        .s_sample_0(s_sample_0), .s_sample_1(s_sample_1), .s_sample_2(s_sample_2),
        .s_sample_3(s_sample_3), .s_sample_4(s_sample_4), .s_sample_5(s_sample_5),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_derivative(m_derivative), .m_divide_fault(m_divide_fault)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Stencils waiting to be offered, and derivatives still owed by the block.
    stencil_t stencil_q[$];
    deriv_t   deriv_q[$];
    logic [RECIP_W-1:0] recip_x = RECIP_RESET;
    logic [RECIP_W-1:0] recip_y = RECIP_RESET;
    int  errors = 0;
    bit  hold_req = 1'b0;

    // ---------------------------------------------------------------------
    // Predictor arithmetic. Every step mirrors the fixed-point definition:
    // products are taken at full width, shifted by the fraction bits and
    // capped; signed products work on the magnitude and restore the sign.
    // ---------------------------------------------------------------------
    function automatic logic [63:0] mul_frac(logic [63:0] a, logic [63:0] b,
                                             logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> FRAC_BITS;
        if (p > {64'd0, cap})
            return cap;
        return p[63:0];
    endfunction

    function automatic logic [63:0] magnitude(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic longint smul_frac(longint a, logic [63:0] b);
        logic [63:0] r;
        r = mul_frac(magnitude(a), b, BIG_CAP);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clamp_sample(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
        lo = -hi - 1;
        return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // Jiang-Shu smoothness indicator from its two polynomial terms.
    function automatic logic [63:0] smoothness(longint b, longint c);
        logic [63:0] sb;
        logic [63:0] sc;
        sb = mul_frac(magnitude(b), magnitude(b), SQ_CAP);
        sc = mul_frac(magnitude(c), magnitude(c), SQ_CAP);
        return (64'd13 * sb + 64'd3 * sc) / 64'd12;
    endfunction

    function automatic deriv_t predict_derivative(stencil_t st, logic [RECIP_W-1:0] rx,
                                                  logic [RECIP_W-1:0] ry);
        longint      smp[SAMPLES];
        longint      v[DIFFS];
        longint      ph[LANES];
        longint      den[LANES];
        logic [63:0] w[LANES];
        logic [63:0] a[LANES];
        logic [63:0] rc;
        logic [63:0] dmin;
        logic [63:0] sum;
        logic [127:0] q;
        longint      vmax;
        longint      eps;
        longint      acc;
        longint      diff;
        deriv_t      res;
        for (int k = 0; k < SAMPLES; k++)
            smp[k] = longint'($signed(st.smp[k]));
        rc = {32'd0, st.axis ? ry : rx};
        // Side minus walks the stencil upward; side plus mirrors it.
        for (int k = 0; k < DIFFS; k++) begin
            diff = st.side ? smp[5-k] - smp[4-k] : smp[k+1] - smp[k];
            v[k] = clamp_sample(smul_frac(diff, rc));
        end
        ph[0] = (2 * v[0] - 7 * v[1] + 11 * v[2]) / 6;
        ph[1] = (-v[1] + 5 * v[2] + 2 * v[3]) / 6;
        ph[2] = (2 * v[2] + 5 * v[3] - v[4]) / 6;
        vmax = v[0];
        for (int k = 1; k < DIFFS; k++)
            if (v[k] > vmax) vmax = v[k];
        eps = vmax / 1000000 + 1;
        den[0] = longint'(smoothness(v[0] - 2*v[1] + v[2], v[0] - 4*v[1] + 3*v[2])) + eps;
        den[1] = longint'(smoothness(v[1] - 2*v[2] + v[3], v[1] - v[3])) + eps;
        den[2] = longint'(smoothness(v[2] - 2*v[3] + v[4], 3*v[2] - 4*v[3] + v[4])) + eps;
        w[0] = 64'(LIN_W0);
        w[1] = 64'(LIN_W1);
        w[2] = 64'(LIN_W2);
        res.fault = 1'b0;
        for (int k = 0; k < LANES; k++)
            if (den[k] <= 0) res.fault = 1'b1;
        // With a nonpositive denominator the linear weights stand as they are.
        if (!res.fault) begin
            dmin = 64'(den[0]);
            for (int k = 1; k < LANES; k++)
                if (64'(den[k]) < dmin) dmin = 64'(den[k]);
            sum = '0;
            for (int k = 0; k < LANES; k++) begin
                q = ({64'd0, dmin} << FRAC_BITS) / {64'd0, 64'(den[k])};
                a[k] = mul_frac(mul_frac(q[63:0], q[63:0], BIG_CAP), w[k], BIG_CAP);
                sum += a[k];
            end
            if (sum != 0)
                for (int k = 0; k < LANES; k++)
                    w[k] = (a[k] << FRAC_BITS) / sum;
        end
        acc = 0;
        for (int k = 0; k < LANES; k++)
            acc += smul_frac(ph[k], w[k]);
        res.deriv = SAMPLE_W'(clamp_sample(acc));
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: bursts of back-to-back items separated by random gaps. The
    // expected derivative is computed at the edge where the item is taken.
    // ---------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        stencil_t st;
        stencil_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cur.side = s_side;
                cur.axis = s_axis;
                cur.smp = {s_sample_5, s_sample_4, s_sample_3,
                           s_sample_2, s_sample_1, s_sample_0};
                deriv_q.push_back(predict_derivative(cur, recip_x, recip_y));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stencil_q.size() > 0) begin
                    st = stencil_q.pop_front();
                    s_side     <= st.side;
                    s_axis     <= st.axis;
                    s_sample_0 <= st.smp[0];
                    s_sample_1 <= st.smp[1];
                    s_sample_2 <= st.smp[2];
                    s_sample_3 <= st.smp[3];
                    s_sample_4 <= st.smp[4];
                    s_sample_5 <= st.smp[5];
                    s_valid    <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // Some bursts are long and gapless, others sparse.
                        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                                               : $urandom_range(0, 8);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: the receiver changes its stall pattern now and then, and one
    // long hold-off lets the pipeline fill until s_ready drops.
    // ---------------------------------------------------------------------
    int  stall_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge aclk) begin
        deriv_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (deriv_q.size() == 0) begin
                    $display("%0t: derivative 0x%08h with no item outstanding",
                             $time, m_derivative);
                    errors++;
                end else begin
                    want = deriv_q.pop_front();
                    if (m_derivative !== want.deriv) begin
                        $display("%0t: derivative expected 0x%08h actual 0x%08h",
                                 $time, want.deriv, m_derivative);
                        errors++;
                    end
                    if (m_divide_fault !== want.fault) begin
                        $display("%0t: divide_fault expected %0b actual %0b",
                                 $time, want.fault, m_divide_fault);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 100);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Watchdog on forward progress of either channel.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("weno5_upwind_derivative regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------
    task automatic write_reg(logic idx, logic [RECIP_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_RECIP_X) recip_x = val;
        else recip_y = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every item has been offered and its result taken, then idles.
    task automatic wait_idle();
        while (stencil_q.size() > 0 || s_valid || deriv_q.size() > 0)
            @(posedge aclk);
        repeat (IDLE_WAIT) @(posedge aclk);
    endtask

    task automatic push_ramp(logic sd, logic ax, int base, int step, int curv);
        stencil_t st;
        st.side = sd;
        st.axis = ax;
        for (int k = 0; k < SAMPLES; k++)
            st.smp[k] = base + step * k + curv * k * k;
        stencil_q.push_back(st);
    endtask

    // Mostly smooth level-set profiles with random content; the rest is
    // raw noise or profiles with a kink, which stress the weights.
    task automatic push_random(int count);
        stencil_t st;
        int base;
        int step;
        int curv;
        int kind;
        for (int n = 0; n < count; n++) begin
            st.side = 1'($urandom_range(0, 1));
            st.axis = 1'($urandom_range(0, 1));
            kind = $urandom_range(0, 9);
            base = $urandom;
            step = $urandom_range(0, 1 << 21) - (1 << 20);
            curv = $urandom_range(0, 1 << 15) - (1 << 14);
            for (int k = 0; k < SAMPLES; k++) begin
                if (kind < 2)
                    st.smp[k] = $urandom;
                else
                    st.smp[k] = base + step * k + curv * k * k
                                + int'($urandom_range(0, 63)) - 32;
            end
            if (kind == 2)
                st.smp[$urandom_range(0, SAMPLES - 1)] = $urandom;
            stencil_q.push_back(st);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset spacing of 1.0 on both axes.
        for (int c = 0; c < 4; c++) begin
            push_ramp(c[0], c[1], 0, 0, 0);                  // flat field
            push_ramp(c[0], c[1], 32'sh1000_0000, 32'sh0001_0000, 0);
        end
        push_ramp(1'b0, 1'b0, 32'sh7fff_ffff, 0, 0);         // all at maximum
        push_ramp(1'b1, 1'b1, 32'sh8000_0000, 0, 0);         // all at minimum
        // Alternating extremes saturate every difference.
        push_ramp(1'b0, 1'b0, 32'sh8000_0000, 32'sh7fff_ffff, 0);
        push_ramp(1'b1, 1'b0, 32'sh7fff_ffff, 32'sh8000_0001, 0);
        // A steep descending ramp drives epsilon below zero and the
        // denominators nonpositive, so the linear weights take over.
        push_ramp(1'b0, 1'b0, 32'sh7000_0000, -32'sh0100_0000, 0);
        push_ramp(1'b1, 1'b1, 32'sh7000_0000, -32'sh0100_0000, 0);
        push_ramp(1'b0, 1'b1, 0, -32'sh0400_0000, 0);
        // Smooth curvature and a kink between the stencils.
        push_ramp(1'b0, 1'b0, 32'sh0001_0000, 32'sh0000_8000, 32'sh0000_1000);
        push_ramp(1'b1, 1'b0, -32'sh0100_0000, 32'sh0002_0000, -32'sh0000_4000);
        push_ramp(1'b0, 1'b1, 0, 0, 32'sh0010_0000);
        push_ramp(1'b1, 1'b1, 5, 1, 0);                      // tiny differences
        push_random(150);
        wait_idle();

        // Unequal spacing, with the long receiver hold-off in this phase.
        write_reg(REG_RECIP_X, 32'h0002_0000);
        write_reg(REG_RECIP_Y, 32'h0000_8000);
        push_random(200);
        hold_req = 1'b1;
        wait_idle();

        // Register extremes: zero scaling on x, the largest on y.
        write_reg(REG_RECIP_X, 32'h0000_0000);
        write_reg(REG_RECIP_Y, 32'hffff_ffff);
        push_ramp(1'b0, 1'b1, 0, 32'sh0000_0001, 0);
        push_ramp(1'b1, 1'b1, 0, -32'sh0000_0001, 0);
        push_random(150);
        wait_idle();

        write_reg(REG_RECIP_X, $urandom);
        write_reg(REG_RECIP_Y, $urandom);
        push_random(200);
        wait_idle();

        write_reg(REG_RECIP_X, 32'h0020_0000);
        write_reg(REG_RECIP_Y, 32'h0000_0100);
        push_random(230);
        wait_idle();

        if (errors == 0)
            $display("weno5_upwind_derivative regression: pass");
        else
            $display("weno5_upwind_derivative regression: fail");
        $finish;
    end

endmodule
